/* rtl/block_task_partitioner_core_macros.svh */
// Assertion macros for the task partitioner block.
// Used by files that hold concurrent checks; expects clk and arst_n in scope.
`ifndef BLOCK_TASK_PARTITIONER_CORE_MACROS_SVH
`define BLOCK_TASK_PARTITIONER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BTP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define BTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/btp_pkg.sv */
// Shared types and constants for the task partitioner block.
// No dependencies; imported by btp_div and block_task_partitioner_core.
package btp_pkg;

	// Field widths
	localparam int TASK_BITS = 20;
	localparam int PROC_BITS = 6;
	// Processor count 1..64 needs one bit more than an id
	localparam int CNT_BITS  = PROC_BITS + 1;
	// Iteration counter of the divider, counts 0..TASK_BITS
	localparam int ITER_BITS = $clog2(TASK_BITS + 1);

	// Request to the shared rounding divider
	typedef struct packed {
		logic                 start;
		logic [TASK_BITS-1:0] dividend;
		logic [CNT_BITS-1:0]  divisor;
	} btp_div_req_t;

	// Response from the shared rounding divider
	typedef struct packed {
		logic                 done;
		logic [TASK_BITS-1:0] quotient;
	} btp_div_rsp_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WAIT
	} btp_state_t;

endpackage

/* rtl/btp_div.sv */
// Iterative restoring divider with round-to-nearest, ties down.
// One quotient bit per cycle; depends on btp_pkg.
module btp_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  btp_pkg::btp_div_req_t req,
	output btp_pkg::btp_div_rsp_t rsp
);
	import btp_pkg::*;

	logic                 active_q;
	logic [ITER_BITS-1:0] cnt_q;
	logic [TASK_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]  divisor_q;
	logic                 done_q;
	logic [TASK_BITS-1:0] result_q;

	logic [CNT_BITS:0]    shifted;
	logic [CNT_BITS:0]    diff;
	logic                 fits;
	logic                 round_up;

	// One restoring step; remainder stays below the divisor
	always_comb begin
		shifted  = {rem_q, quo_q[TASK_BITS-1]};
		diff     = shifted - {1'b0, divisor_q};
		fits     = shifted >= {1'b0, divisor_q};
		// 2*rem > divisor means the fraction is above one half
		round_up = {rem_q, 1'b0} > {1'b0, divisor_q};
	end

	// Control: active flag, step counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (cnt_q == ITER_BITS'(TASK_BITS)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (active_q) begin
			if (cnt_q == ITER_BITS'(TASK_BITS)) begin
				result_q <= quo_q + TASK_BITS'(round_up);
			end else begin
				rem_q <= fits ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
				quo_q <= {quo_q[TASK_BITS-2:0], fits};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = result_q;

endmodule

/* rtl/block_task_partitioner_core.sv */
// Task partitioner: one result per processor, shares from a shared rounding divider.
// Per result: S_START starts the divider, S_WAIT awaits done, then the payload is registered.
// A request for N processors occupies the block for N divisions, one per processor.
// busy is high from the cycle after start until the last result is registered.
// A request with last below first yields no result and leaves the block idle.
// Asynchronous active-low reset returns the sequencer to idle; results never stall.
module block_task_partitioner_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [btp_pkg::TASK_BITS-1:0]   task_count,
	input  logic [btp_pkg::PROC_BITS-1:0]   first_proc,
	input  logic [btp_pkg::PROC_BITS-1:0]   last_proc,
	output logic                            result_valid,
	output logic [btp_pkg::PROC_BITS-1:0]   proc_id,
	output logic [btp_pkg::TASK_BITS-1:0]   assigned_count,
	output logic [btp_pkg::TASK_BITS:0]     first_task,
	output logic [btp_pkg::TASK_BITS-1:0]   last_task,
	output logic                            last_in_run
);
	import btp_pkg::*;
	`include "block_task_partitioner_core_macros.svh"

	btp_state_t           state_q, state_d;
	logic [TASK_BITS-1:0] tasks_left_q;
	logic [CNT_BITS-1:0]  procs_left_q;
	logic [TASK_BITS-1:0] high_mark_q;
	logic [PROC_BITS-1:0] cur_proc_q;
	logic [PROC_BITS-1:0] last_proc_q;
	logic                 result_valid_q;
	logic [PROC_BITS-1:0] proc_id_q;
	logic [TASK_BITS-1:0] assigned_q;
	logic [TASK_BITS:0]   first_task_q;
	logic [TASK_BITS-1:0] last_task_q;
	logic                 last_in_run_q;

	btp_div_req_t         div_req;
	btp_div_rsp_t         div_rsp;

	logic                 accept;
	logic                 empty_run;
	logic                 at_last;
	logic [TASK_BITS:0]   span_check;

	assign accept    = start && !busy;
	assign empty_run = last_proc < first_proc;
	assign at_last   = cur_proc_q == last_proc_q;

	// Shared rounding divider
	btp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept && !empty_run) state_d = S_START;
			S_START: state_d = S_WAIT;
			S_WAIT:  if (div_rsp.done) state_d = at_last ? S_IDLE : S_START;
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		busy             = 1'b1;
		div_req.start    = 1'b0;
		div_req.dividend = tasks_left_q;
		div_req.divisor  = procs_left_q;
		unique case (state_q)
			S_IDLE:  busy = 1'b0;
			S_START: div_req.start = 1'b1;
			S_WAIT:  ;
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= (state_q == S_WAIT) && div_rsp.done;
		end
	end

	// Run bookkeeping and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			tasks_left_q <= task_count;
			procs_left_q <= CNT_BITS'(last_proc - first_proc) + 1'b1;
			high_mark_q  <= '0;
			cur_proc_q   <= first_proc;
			last_proc_q  <= last_proc;
		end else if (state_q == S_WAIT && div_rsp.done) begin
			tasks_left_q  <= tasks_left_q - div_rsp.quotient;
			procs_left_q  <= procs_left_q - 1'b1;
			high_mark_q   <= high_mark_q + div_rsp.quotient;
			cur_proc_q    <= cur_proc_q + 1'b1;
			proc_id_q     <= cur_proc_q;
			assigned_q    <= div_rsp.quotient;
			first_task_q  <= {1'b0, high_mark_q} + 1'b1;
			last_task_q   <= high_mark_q + div_rsp.quotient;
			last_in_run_q <= at_last;
		end
	end

	assign result_valid   = result_valid_q;
	assign proc_id        = proc_id_q;
	assign assigned_count = assigned_q;
	assign first_task     = first_task_q;
	assign last_task      = last_task_q;
	assign last_in_run    = last_in_run_q;

	// Share bounds: last_task + 1 == first_task + count
	assign span_check = {1'b0, last_task_q} + 1'b1 - {1'b0, assigned_q};

	`BTP_ASSERT_NOW(a_span, result_valid_q, span_check == first_task_q, "share span mismatch")
	`BTP_ASSERT_NOW(a_div_wait, div_rsp.done, state_q == S_WAIT, "divider done outside wait")
	`BTP_ASSERT_NEXT(a_empty, accept && empty_run, !busy, "empty request left block busy")
	`BTP_ASSERT_NOW(a_final, result_valid_q && last_in_run_q, !busy, "busy after final item")
	`BTP_ASSERT_NOW(a_mid, result_valid_q && !last_in_run_q, busy, "idle before final item")

endmodule

/* dv/block_task_partitioner_core_tb.sv */
// Self-checking testbench for block_task_partitioner_core: predicts each processor's share
// of a task run and compares it with every result the block emits.
// Depends on rtl/btp_pkg.sv and rtl/block_task_partitioner_core.sv.
`timescale 1ns / 1ps

module block_task_partitioner_core_tb;

	localparam int TB = btp_pkg::TASK_BITS;
	localparam int PB = btp_pkg::PROC_BITS;
	localparam int MAX_SPAN = 64;
	localparam int RAND_ITEMS = 220;
	localparam int DRAIN_CYCLES = 60;

	// One request as queued for the driver
	typedef struct {
		logic [TB-1:0] tasks;
		logic [PB-1:0] first;
		logic [PB-1:0] last;
		int            gap_pct;
		bit            drain;
	} request_t;

	// One processor's share as the block should report it
	typedef struct {
		logic [PB-1:0] proc;
		logic [TB-1:0] count;
		logic [TB:0]   lo;
		logic [TB-1:0] hi;
		logic          tail;
	} share_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [TB-1:0] task_count = '0;
	logic [PB-1:0] first_proc = '0;
	logic [PB-1:0] last_proc = '0;
	logic          busy;
	logic          result_valid;
	logic [PB-1:0] proc_id;
	logic [TB-1:0] assigned_count;
	logic [TB:0]   first_task;
	logic [TB-1:0] last_task;
	logic          last_in_run;

	request_t request_q[$];
	share_t   share_q[$];
	request_t in_flight;
	int       n_requests = 0;
	int       n_empty = 0;
	int       n_shares = 0;
	int       n_errors = 0;

	block_task_partitioner_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.task_count(task_count),
		.first_proc(first_proc),
		.last_proc(last_proc),
		.result_valid(result_valid),
		.proc_id(proc_id),
		.assigned_count(assigned_count),
		.first_task(first_task),
		.last_task(last_task),
		.last_in_run(last_in_run)
	);

	// Share predictor: remaining tasks over remaining processors, rounded to
	// nearest with an exact tie going down; one share per processor in order.
	function automatic void compute_shares(input request_t rq);
		logic [63:0]   left;
		logic [63:0]   procs;
		logic [63:0]   q;
		logic [63:0]   mark;
		logic [63:0]   lo;
		logic [PB-1:0] cur;
		share_t        s;
		if (rq.last < rq.first) begin
			n_empty++;
			return;
		end
		left = 64'(rq.tasks);
		procs = 64'(rq.last) - 64'(rq.first) + 64'd1;
		mark = 0;
		cur = rq.first;
		while (procs != 0) begin
			q = left / procs;
			if ((2 * q + 1) * procs < 2 * left)
				q++;
			if (q > left)
				q = left;
			lo = mark + 1;
			left = left - q;
			procs = procs - 1;
			mark = (mark + q) & ((64'd1 << TB) - 1);
			s.proc = cur;
			s.count = q[TB-1:0];
			s.lo = lo[TB:0];
			s.hi = mark[TB-1:0];
			s.tail = (cur == rq.last);
			share_q.push_back(s);
			if (cur == rq.last)
				break;
			cur++;
		end
	endfunction

	function automatic request_t make_request(input logic [TB-1:0] tasks,
			input int first, input int last, input int gap_pct, input bit drain);
		request_t rq;
		rq.tasks = tasks;
		rq.first = first[PB-1:0];
		rq.last = last[PB-1:0];
		rq.gap_pct = gap_pct;
		rq.drain = drain;
		return rq;
	endfunction

	// Random request: mostly short spans, some full-range and reversed ranges
	function automatic request_t random_request(input int gap_pct, input bit drain);
		int            kind;
		int            first;
		int            last;
		int            tsel;
		logic [TB-1:0] tasks;
		kind = $urandom_range(99);
		tsel = $urandom_range(99);
		if (kind < 10) begin
			first = $urandom_range(MAX_SPAN - 1, 1);
			last = $urandom_range(first - 1, 0);
		end else if (kind < 25) begin
			first = $urandom_range(MAX_SPAN - 1);
			last = $urandom_range(MAX_SPAN - 1);
		end else begin
			first = $urandom_range(MAX_SPAN - 1);
			last = first + $urandom_range(7);
			if (last > MAX_SPAN - 1)
				last = MAX_SPAN - 1;
		end
		if (tsel < 20)
			tasks = TB'($urandom_range(20));
		else if (tsel < 40)
			tasks = TB'($urandom_range(1000));
		else if (tsel < 50)
			tasks = {TB{1'b1}} - TB'($urandom_range(3));
		else
			tasks = TB'($urandom);
		return make_request(tasks, first, last, gap_pct, drain);
	endfunction

	// Clock
	initial begin
		forever #5 clk = ~clk;
	end

	// Driver: holds start until the item is taken, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			task_count <= '0;
			first_proc <= '0;
			last_proc <= '0;
		end else begin
			if (start && !busy) begin
				compute_shares(in_flight);
				n_requests++;
			end
			if (start && busy) begin
				// item still waiting to be taken
			end else if (request_q.size() == 0
					|| (request_q[0].drain && (share_q.size() != 0 || busy))
					|| $urandom_range(99) < request_q[0].gap_pct) begin
				// idle: noise on the fields while start is low
				start <= 1'b0;
				task_count <= TB'($urandom);
				first_proc <= PB'($urandom);
				last_proc <= PB'($urandom);
			end else begin
				in_flight = request_q.pop_front();
				start <= 1'b1;
				task_count <= in_flight.tasks;
				first_proc <= in_flight.first;
				last_proc <= in_flight.last;
			end
		end
	end

	// Monitor: every strobed result against the oldest predicted share
	always @(posedge clk) begin
		share_t s;
		if (arst_n && result_valid) begin
			if (share_q.size() == 0) begin
				$error("unexpected result for proc_id %0d", proc_id);
				n_errors++;
			end else begin
				s = share_q.pop_front();
				n_shares++;
				if (proc_id !== s.proc) begin
					$error("proc_id: expected %0d, got %0d", s.proc, proc_id);
					n_errors++;
				end
				if (assigned_count !== s.count) begin
					$error("assigned_count: expected %0d, got %0d", s.count, assigned_count);
					n_errors++;
				end
				if (first_task !== s.lo) begin
					$error("first_task: expected %0d, got %0d", s.lo, first_task);
					n_errors++;
				end
				if (last_task !== s.hi) begin
					$error("last_task: expected %0d, got %0d", s.hi, last_task);
					n_errors++;
				end
				if (last_in_run !== s.tail) begin
					$error("last_in_run: expected %0d, got %0d", s.tail, last_in_run);
					n_errors++;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int phase_gap[4];
		// gap percentage per phase; results cannot be held off, so no phase stalls the receiver
		phase_gap = '{0, 76, 0, 26};

		// directed: extremes, ties, empty and reversed ranges
		request_q.push_back(make_request(0, 0, 0, 0, 0));
		request_q.push_back(make_request({TB{1'b1}}, 0, 0, 0, 0));
		request_q.push_back(make_request(0, 3, 7, 0, 0));
		request_q.push_back(make_request(5, 10, 11, 0, 0));
		request_q.push_back(make_request(3, 20, 21, 0, 0));
		request_q.push_back(make_request(7, 40, 43, 0, 0));
		request_q.push_back(make_request(9, 5, 2, 0, 0));
		request_q.push_back(make_request(100, 63, 0, 0, 0));
		request_q.push_back(make_request(1, 0, 63, 0, 0));
		request_q.push_back(make_request({TB{1'b1}}, 0, 63, 0, 0));
		request_q.push_back(make_request(63, 63, 63, 0, 0));
		request_q.push_back(make_request(10, 60, 63, 0, 0));
		request_q.push_back(make_request(20'h55555, 62, 63, 0, 1));
		request_q.push_back(make_request(20'hAAAAA, 1, 0, 0, 0));
		request_q.push_back(make_request(2, 30, 34, 0, 0));

		// random phases, each opening after the previous one has drained
		for (int p = 0; p < 4; p++)
			for (int i = 0; i < RAND_ITEMS / 4; i++)
				request_q.push_back(random_request(phase_gap[p], i == 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (request_q.size() != 0 || start)
			@(posedge clk);
		while (share_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d with a reversed range) and checked %0d shares,",
			n_requests, n_empty, n_shares);
		$display("under full-rate and gapped start traffic with drained pauses.");
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/btp_pkg.sv
rtl/btp_div.sv
rtl/block_task_partitioner_core.sv
dv/block_task_partitioner_core_tb.sv
